[rtl/core/smpb_pkg.sv]
// ----------------------------------------------------------------------------
// smpb_pkg: shared types and constants of the saturating mix playout buffer
// holds the store geometry, the level thresholds, the register map and the
// packed transaction payloads
// ----------------------------------------------------------------------------
package smpb_pkg;

	// ring depth, a power of two from 1024 to 1048576
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int SAMPLE_W    = 16;
	localparam int LEVEL_W     = 5;
	localparam int LEVEL_STEPS = 20;

	localparam logic signed [SAMPLE_W:0] MIX_LIMIT = 17'sd32766;
	localparam logic [14:0]              OUT_GAIN  = 15'd32766;

	// peak thresholds for 0.99/1.25^k of full scale
	localparam logic [15:0] LEVEL_THRESH [LEVEL_STEPS] = '{
		16'd32441, 16'd25953, 16'd20762, 16'd16610, 16'd13288,
		16'd10631, 16'd8505,  16'd6804,  16'd5443,  16'd4355,
		16'd3484,  16'd2787,  16'd2230,  16'd1784,  16'd1427,
		16'd1142,  16'd914,   16'd731,   16'd585,   16'd468
	};

	// register map
	localparam int          PADDR_W       = 3;
	localparam logic        REG_PLAY_MUTE = 1'b0;

	typedef enum logic {
		OP_MIX  = 1'b0,
		OP_PLAY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        operation;
		logic [15:0]                offset;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       frame_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [LEVEL_W-1:0]         level;
		logic                       level_valid;
	} out_item_t;

	// number of thresholds at or below the peak
	function automatic logic [LEVEL_W-1:0] peak_level(input logic [15:0] peak);
		logic [LEVEL_W-1:0] n;
		n = '0;
		for (int i = 0; i < LEVEL_STEPS; i++) begin
			if (peak >= LEVEL_THRESH[i]) begin
				n = n + 1'b1;
			end
		end
		return n;
	endfunction

endpackage

[rtl/core/saturating_mix_playout_buffer.sv]
// ----------------------------------------------------------------------------
// saturating_mix_playout_buffer: ring buffer that mixes and plays 16-bit audio
// mix transactions add a sample at an offset ahead of the read head with
// saturation and track the frame peak; play transactions read, clear and
// scale (or zero, while muted) the sample at the head
// ----------------------------------------------------------------------------
// pipeline: an accepted transaction passes stage 1, then the output register
// throughput: one transaction per cycle unless out_ready stalls it; the single
//   ring ram takes one read at acceptance and one write-back when the item
//   leaves stage 1; a forwarding register covers back-to-back same-slot access
// reset: after arst_n the ring is cleared one slot per cycle, all STORE_DEPTH
//   slots (65536 by default), with in_ready low; config writes are taken
// ----------------------------------------------------------------------------
module saturating_mix_playout_buffer
	import smpb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,

	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// ring storage, no reset: contents come from the clearing pass
	logic signed [SAMPLE_W-1:0] mix_store [STORE_DEPTH];

	// control and config
	logic              mute_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] head_q;
	logic [15:0]       peak_q;

	// stage 1: ram read data returns here
	logic                       v_s1;
	op_t                        op_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic [15:0]                mag_s1;
	logic signed [SAMPLE_W-1:0] rdata_s1;

	// last write-back, forwarded to a read issued on the same edge
	logic                       fwd_v_q;
	logic [ADDR_W-1:0]          fwd_addr_q;
	logic signed [SAMPLE_W-1:0] fwd_data_q;

	// output register
	logic      out_v_q;
	out_item_t out_data_q;

	// handshake
	logic in_fire;
	logic s1_adv;

	// ram port signals
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic signed [SAMPLE_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]          mem_raddr;

	// stage 1 datapath
	logic signed [SAMPLE_W-1:0] old_val;
	logic signed [SAMPLE_W:0]   mix_sum;
	logic signed [SAMPLE_W-1:0] mix_sat;
	logic [15:0]                old_mag;
	logic [30:0]                scale_prod;
	logic [15:0]                scale_mag;
	logic signed [SAMPLE_W-1:0] play_val;
	logic [15:0]                peak_new;
	logic [15:0]                in_mag;
	out_item_t                  res;

	// ------------------------------------------------------------------------
	// config port: one register, play_mute at word 0
	// ------------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PLAY_MUTE)) begin
			mute_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PLAY_MUTE) begin
			prdata[0] = mute_q;
		end
	end

	// ------------------------------------------------------------------------
	// handshake: stage 1 moves on when the output register is free or drains
	// ------------------------------------------------------------------------
	assign s1_adv   = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !clr_busy_q && (!v_s1 || s1_adv);
	assign in_fire  = in_valid && in_ready;

	// magnitude of the incoming sample, -32768 gives 32768
	assign in_mag = in_data.sample_in[SAMPLE_W-1] ?
		16'(~in_data.sample_in + 16'sd1) : 16'(in_data.sample_in);

	// read address: head for play, head plus offset (wrapping) for mix
	assign mem_raddr = (in_data.operation == OP_PLAY) ? head_q
		: head_q + ADDR_W'(in_data.offset);

	// ------------------------------------------------------------------------
	// clearing pass after reset
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// read head advances as a play transaction is accepted
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (in_fire && (in_data.operation == OP_PLAY)) begin
			head_q <= head_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// stage 1 registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= in_data.operation;
			addr_s1   <= mem_raddr;
			sample_s1 <= in_data.sample_in;
			last_s1   <= in_data.frame_last;
			mag_s1    <= in_mag;
		end
	end

	// ------------------------------------------------------------------------
	// ring ram: synchronous read on acceptance, write-back from stage 1 or
	// the clearing pass
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mix_store[mem_waddr] <= mem_wdata;
		end
		if (in_fire) begin
			rdata_s1 <= mix_store[mem_raddr];
		end
	end

	// the write of the item leaving stage 1 lands on the same edge as the
	// next read, so the read may see stale data: take the forwarded value
	assign old_val = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata_s1;

	// mix: saturating add
	assign mix_sum = 17'(old_val) + 17'(sample_s1);

	always_comb begin
		if (mix_sum > MIX_LIMIT) begin
			mix_sat = 16'(MIX_LIMIT);
		end else if (mix_sum < -MIX_LIMIT) begin
			mix_sat = 16'(-MIX_LIMIT);
		end else begin
			mix_sat = 16'(mix_sum);
		end
	end

	// play: scale magnitude by 32766/32768, truncated toward zero
	assign old_mag    = old_val[SAMPLE_W-1] ? 16'(-old_val) : 16'(old_val);
	assign scale_prod = 31'(old_mag) * 31'(OUT_GAIN);
	assign scale_mag  = scale_prod[30:15];
	assign play_val   = old_val[SAMPLE_W-1] ? -$signed(scale_mag) : $signed(scale_mag);

	// frame peak including the current sample
	assign peak_new = (mag_s1 > peak_q) ? mag_s1 : peak_q;

	// write port: clearing pass owns it until done, then stage 1
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = '0;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (s1_adv) begin
			mem_we    = 1'b1;
			mem_wdata = (op_s1 == OP_MIX) ? mix_sat : '0;
		end
	end

	// result of the item in stage 1
	always_comb begin
		res = '0;
		if (op_s1 == OP_PLAY) begin
			res.sample_out = mute_q ? '0 : play_val;
		end else if (last_s1) begin
			res.level       = peak_level(peak_new);
			res.level_valid = 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// forwarding register and frame peak
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
			peak_q  <= '0;
		end else if (s1_adv) begin
			fwd_v_q <= 1'b1;
			if (op_s1 == OP_MIX) begin
				peak_q <= last_s1 ? '0 : peak_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= mem_wdata;
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;

endmodule
